// ----- sv/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, widths and codes of the two-track step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  // Pattern geometry.
  localparam int unsigned STEPS  = 256;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam int unsigned LEN_W  = $clog2(STEPS + 1);

  // Register widths.
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned DEB_W    = 8;
  localparam int unsigned CNT_W    = 12;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(59);
  localparam logic [DEB_W-1:0]    DEB_RST    = DEB_W'(29);
  localparam logic [CNT_W-1:0]    LONG_RST   = CNT_W'(1500);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    MODE_PAUSE = 2'd0,
    MODE_PLAY  = 2'd1,
    MODE_REC   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    BTN_IDLE     = 2'd0,
    BTN_DEBOUNCE = 2'd1,
    BTN_HELD     = 2'd2
  } btn_e;

  typedef enum logic [1:0] {
    PRESS_NONE  = 2'd0,
    PRESS_SHORT = 2'd1,
    PRESS_LONG  = 2'd2
  } press_e;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic   tick;
    logic   pad_a;
    logic   pad_b;
    logic   play;
    press_e cls;
  } tts_item_t;

endpackage

`default_nettype wire

// ----- sv/tts_if.sv -----
// ----------------------------------------------------------------------------
// tts_in_if / tts_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic pad_a_press;
  logic pad_b_press;
  logic play_press;
  logic rec_press;
  logic rec_released;

  modport source (output valid, tick, pad_a_press, pad_b_press, play_press,
                  rec_press, rec_released, input ready);
  modport sink   (input valid, tick, pad_a_press, pad_b_press, play_press,
                  rec_press, rec_released, output ready);
endinterface

interface tts_out_if;
  import tts_pkg::*;
  logic             valid;
  logic             ready;
  logic             track_a_level;
  logic             track_b_level;
  logic [1:0]       mode;
  logic [STEP_W-1:0] step_index;
  logic [LEN_W-1:0] loop_length;
  logic             trimmed;
  logic [1:0]       press_class;

  modport source (output valid, track_a_level, track_b_level, mode, step_index,
                  loop_length, trimmed, press_class, input ready);
  modport sink   (input valid, track_a_level, track_b_level, mode, step_index,
                  loop_length, trimmed, press_class, output ready);
endinterface

`default_nettype wire

// ----- sv/tts_ram.sv -----
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/tts_queue.sv -----
// ----------------------------------------------------------------------------
// tts_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  input  wire tts_pkg::tts_item_t push_item_i,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i,
  output tts_pkg::tts_item_t      pop_item_o
);
  import tts_pkg::*;

  tts_item_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tts_front.sv -----
// ----------------------------------------------------------------------------
// tts_front
// Accepts input items and classifies the record button press.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  tts_in_if.sink                            item_i,
  input  wire logic [tts_pkg::DEB_W-1:0]    debounce_ticks_i,
  input  wire logic [tts_pkg::CNT_W-1:0]    long_press_ticks_i,
  output logic                              push_valid_o,
  input  wire logic                         push_ready_i,
  output tts_pkg::tts_item_t                push_item_o
);
  import tts_pkg::*;

  btn_e             btn_q, btn_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_inc;
  press_e           cls;
  logic             accept;

  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid;
  assign accept       = item_i.valid && push_ready_i;

  // The hold counter saturates at its top value.
  assign cnt_inc = (item_i.tick && (cnt_q != {CNT_W{1'b1}})) ? cnt_q + CNT_W'(1) : cnt_q;

  always_comb begin
    btn_d = btn_q;
    cnt_d = cnt_q;
    cls   = PRESS_NONE;
    case (btn_q)
      BTN_DEBOUNCE: begin
        cnt_d = cnt_inc;
        if (cnt_inc > {{(CNT_W-DEB_W){1'b0}}, debounce_ticks_i}) begin
          btn_d = BTN_HELD;
        end
      end
      BTN_HELD: begin
        cnt_d = cnt_inc;
        if (item_i.rec_released) begin
          btn_d = BTN_IDLE;
          cls   = PRESS_SHORT;
        end
        // A long hold wins over a release in the same item.
        if (cnt_inc >= long_press_ticks_i) begin
          btn_d = BTN_IDLE;
          cls   = PRESS_LONG;
        end
      end
      default: begin
        btn_d = BTN_IDLE;
        if (item_i.rec_press) begin
          btn_d = BTN_DEBOUNCE;
          cnt_d = '0;
        end
      end
    endcase
  end

  always_comb begin
    push_item_o.tick  = item_i.tick;
    push_item_o.pad_a = item_i.pad_a_press;
    push_item_o.pad_b = item_i.pad_b_press;
    push_item_o.play  = item_i.play_press;
    push_item_o.cls   = cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q <= BTN_IDLE;
      cnt_q <= '0;
    end else if (accept) begin
      btn_q <= btn_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tts_back.sv -----
// ----------------------------------------------------------------------------
// tts_back
// Sequencer: mode and step control, pattern store access and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pop_valid_i,
  output logic                               pop_ready_o,
  input  wire tts_pkg::tts_item_t            pop_item_i,
  input  wire logic [tts_pkg::PERIOD_W-1:0]  step_period_ticks_i,
  tts_out_if.source                          result_o
);
  import tts_pkg::*;

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(STEPS);

  // Control stage state.
  mode_e             mode_q, mode_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PERIOD_W-1:0] ms_q, ms_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              trim_q, trim_d;
  logic [2:0]        pend_q, pend_d;

  logic [STEP_W-1:0] x_idx;
  logic [1:0]        x_wbits;
  logic              x_use, x_write, x_clear;
  logic [PERIOD_W-1:0] ms_adv;
  logic [LEN_W-1:0]  step_adv;
  logic              x_fire;

  // Pattern stage registers.
  logic              m_valid_q;
  logic [STEP_W-1:0] m_idx_q;
  logic [1:0]        m_wbits_q;
  logic              m_use_q, m_write_q, m_clear_q;
  mode_e             m_mode_q;
  logic [STEP_W-1:0] m_step_q;
  logic [LEN_W-1:0]  m_len_q;
  logic              m_trim_q;
  press_e            m_cls_q;
  logic              fwd_hit_q;
  logic [1:0]        fwd_data_q;
  logic [1:0]        hold_q, hold_d;
  logic [STEPS-1:0]  written_q;
  logic [1:0]        rdata, old_val, new_val;
  logic              m_fire, ram_we;

  // Result register.
  logic              o_valid_q;
  logic [1:0]        o_hold_q;
  mode_e             o_mode_q;
  logic [STEP_W-1:0] o_step_q;
  logic [LEN_W-1:0]  o_len_q;
  logic              o_trim_q;
  press_e            o_cls_q;

  assign m_fire      = m_valid_q && (!o_valid_q || result_o.ready);
  assign pop_ready_o = !m_valid_q || m_fire;
  assign x_fire      = pop_valid_i && pop_ready_o;

  always_comb begin
    mode_d  = mode_q;
    step_d  = step_q;
    ms_d    = ms_q;
    len_d   = len_q;
    trim_d  = trim_q;
    pend_d  = pend_q | {pop_item_i.play, pop_item_i.pad_b, pop_item_i.pad_a};
    x_wbits = 2'b00;
    x_use   = 1'b0;
    x_write = 1'b0;
    x_clear = 1'b0;

    // Step timing, used in play and record.
    ms_adv   = pop_item_i.tick ? ms_q + PERIOD_W'(1) : ms_q;
    step_adv = {1'b0, step_q};
    if (ms_adv >= step_period_ticks_i) begin
      step_adv = step_adv + LEN_W'(1);
      ms_adv   = '0;
    end
    if ((step_adv >= len_q) || (step_adv >= LEN_FULL)) begin
      step_adv = '0;
    end
    x_idx = step_adv[STEP_W-1:0];

    case (mode_q)
      MODE_PLAY: begin
        ms_d   = ms_adv;
        step_d = x_idx;
        x_use  = 1'b1;
        if (pop_item_i.cls == PRESS_SHORT) begin
          mode_d = MODE_REC;
          step_d = '0;
        end
        if (pop_item_i.cls == PRESS_LONG) begin
          x_clear = 1'b1;
        end
        if (pend_d[2]) begin
          mode_d    = MODE_PAUSE;
          pend_d[2] = 1'b0;
          step_d    = '0;
        end
      end
      MODE_REC: begin
        ms_d        = ms_adv;
        step_d      = x_idx;
        x_use       = 1'b1;
        x_write     = 1'b1;
        x_wbits     = pend_d[1:0];
        pend_d[1:0] = 2'b00;
        if (pop_item_i.cls == PRESS_SHORT) begin
          mode_d = MODE_PAUSE;
          trim_d = 1'b1;
          len_d  = step_adv;
          step_d = '0;
        end
        if (pop_item_i.cls == PRESS_LONG) begin
          x_clear = 1'b1;
        end
      end
      default: begin
        mode_d = MODE_PAUSE;
        if (pop_item_i.cls == PRESS_SHORT) begin
          mode_d = MODE_REC;
        end
        if (pop_item_i.cls == PRESS_LONG) begin
          x_clear = 1'b1;
        end
        if (pend_d[2]) begin
          mode_d    = MODE_PLAY;
          pend_d[2] = 1'b0;
          step_d    = '0;
        end
      end
    endcase

    // A long press clears after the pads are written; play may then override.
    if (x_clear) begin
      trim_d = 1'b0;
      len_d  = LEN_FULL;
      if (!((mode_q == MODE_PLAY) && pend_q[2]) && !((mode_q == MODE_PLAY) &&
          pop_item_i.play) && !((mode_q != MODE_PLAY) && (mode_q != MODE_REC) &&
          (pend_q[2] || pop_item_i.play))) begin
        mode_d = MODE_PAUSE;
      end
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PAUSE;
      step_q <= '0;
      ms_q   <= '0;
      len_q  <= LEN_FULL;
      trim_q <= 1'b0;
      pend_q <= 3'b000;
    end else if (x_fire) begin
      mode_q <= mode_d;
      step_q <= step_d;
      ms_q   <= ms_d;
      len_q  <= len_d;
      trim_q <= trim_d;
      pend_q <= pend_d;
    end
  end

  // Pattern stage. Entries never written since the last clear read as zero;
  // a write by the item just ahead is forwarded past the registered read.
  always_comb begin
    old_val = fwd_hit_q ? fwd_data_q : (written_q[m_idx_q] ? rdata : 2'b00);
    new_val = old_val | m_wbits_q;
    hold_d  = m_use_q ? new_val : hold_q;
  end

  assign ram_we = m_fire && m_write_q && !m_clear_q;

  tts_ram #(
    .WIDTH (2),
    .DEPTH (STEPS)
  ) u_pattern (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (m_idx_q),
    .wdata_i (new_val),
    .re_i    (x_fire),
    .raddr_i (x_idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
      hold_q    <= 2'b00;
      written_q <= '0;
    end else begin
      if (x_fire) begin
        m_valid_q <= 1'b1;
        fwd_hit_q <= ram_we && (m_idx_q == x_idx);
      end else if (m_fire) begin
        m_valid_q <= 1'b0;
      end
      if (m_fire) begin
        hold_q <= hold_d;
        if (m_clear_q) begin
          written_q <= '0;
        end else if (m_write_q) begin
          written_q[m_idx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_fire) begin
      m_idx_q    <= x_idx;
      m_wbits_q  <= x_wbits;
      m_use_q    <= x_use;
      m_write_q  <= x_write;
      m_clear_q  <= x_clear;
      m_mode_q   <= mode_d;
      m_step_q   <= step_d;
      m_len_q    <= len_d;
      m_trim_q   <= trim_d;
      m_cls_q    <= pop_item_i.cls;
      fwd_data_q <= new_val;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (m_fire) begin
      o_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_fire) begin
      o_hold_q <= hold_d;
      o_mode_q <= m_mode_q;
      o_step_q <= m_step_q;
      o_len_q  <= m_len_q;
      o_trim_q <= m_trim_q;
      o_cls_q  <= m_cls_q;
    end
  end

  assign result_o.valid         = o_valid_q;
  assign result_o.track_a_level = o_hold_q[0];
  assign result_o.track_b_level = o_hold_q[1];
  assign result_o.mode          = o_mode_q;
  assign result_o.step_index    = o_step_q;
  assign result_o.loop_length   = o_len_q;
  assign result_o.trimmed       = o_trim_q;
  assign result_o.press_class   = o_cls_q;

endmodule

`default_nettype wire

// ----- sv/two_track_step_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// two_track_step_sequencer_core
// Two-track step sequencer with pause, play and record modes and a
// long-press record button.
//
//   Channel   Direction  Handshake     Content
//   item_i    in         valid/ready   tick, pad, play and record button events
//   result_o  out        valid/ready   track levels, mode, step, length, press
//   cfg_*     in         write enable  step period, debounce, long press ticks
//
// One item per cycle is sustained while results are taken. The result of an item
// is valid once the item has passed classification into the queue at the accepting
// edge, mode and step control with the pattern read into the pattern stage, and the
// pattern update into the result register.
// Reset clears all state at once; the pattern store needs no clearing pass.
// A stalled result fills the queue, after which item_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module two_track_step_sequencer_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  tts_in_if.sink                               item_i,
  tts_out_if.source                            result_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [tts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tts_pkg::CFG_W-1:0]       cfg_data_i
);
  import tts_pkg::*;

  logic [PERIOD_W-1:0] period_q;
  logic [DEB_W-1:0]    deb_q;
  logic [CNT_W-1:0]    long_q;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  tts_item_t push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      deb_q    <= DEB_RST;
      long_q   <= LONG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_DEBOUNCE:    deb_q    <= cfg_data_i[DEB_W-1:0];
        CFG_LONG_PRESS:  long_q   <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  tts_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_i             (item_i),
    .debounce_ticks_i   (deb_q),
    .long_press_ticks_i (long_q),
    .push_valid_o       (push_valid),
    .push_ready_i       (push_ready),
    .push_item_o        (push_item)
  );

  tts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  tts_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pop_valid_i         (pop_valid),
    .pop_ready_o         (pop_ready),
    .pop_item_i          (pop_item),
    .step_period_ticks_i (period_q),
    .result_o            (result_o)
  );

endmodule

`default_nettype wire
